// ===== sv/bedge_pkg.sv =====
`default_nettype none

package bedge_pkg;

    localparam int IMAGE_SIDE = 256;
    localparam int COL_W      = $clog2(IMAGE_SIDE);
    localparam int CNT_W      = $clog2(IMAGE_SIDE * IMAGE_SIDE + 1);

    localparam logic [CNT_W-1:0] FRAME_PIXELS = CNT_W'(IMAGE_SIDE * IMAGE_SIDE);
    localparam logic [CNT_W-1:0] LEAD_PIXELS  = CNT_W'(IMAGE_SIDE + 1);
    localparam logic [COL_W-1:0] LAST_COL     = COL_W'(IMAGE_SIDE - 1);

    localparam logic       CMD_PIXEL = 1'b0;
    localparam logic       CMD_DRAIN = 1'b1;

    localparam logic [7:0] THRESHOLD_RESET = 8'd128;
    localparam logic [7:0] EDGE_BOUNDARY   = 8'd0;
    localparam logic [7:0] EDGE_OTHER      = 8'd255;

    localparam logic [8:0] NEIGHBOUR_MASK = 9'b111_101_111;
    localparam logic [8:0] LEFT_COLUMN    = 9'b000_000_111;
    localparam logic [8:0] RIGHT_COLUMN   = 9'b111_000_000;
    localparam logic [8:0] TOP_ROW        = 9'b001_001_001;
    localparam logic [8:0] BOTTOM_ROW     = 9'b100_100_100;

    typedef struct packed {
        logic       command;
        logic [7:0] pixel_value;
    } pix_t;

    typedef struct packed {
        logic [7:0] edge_pixel;
        logic       last_of_frame;
    } res_t;

    typedef struct packed {
        logic left;
        logic right;
        logic top;
        logic bottom;
    } border_t;

    typedef struct packed {
        logic             emit;
        logic             bit_in;
        logic [COL_W-1:0] col;
        border_t          border;
        logic             last;
    } stage_t;

endpackage

`default_nettype wire

// ===== sv/bedge_ram.sv =====
`default_nettype none

module bedge_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/binary_edge_detect_3x3.sv =====
`default_nettype none
// Path: an accepted item waits in stage B and is registered as a result once the output
//   is free; in stream terms each output follows its pixel by one row plus one pixel.
// Throughput: one item per cycle unless stalled, set by the line memory, read at
//   acceptance, written by stage B; the next item reads another column, except the
//   first pixel after a frame end, whose stale read only reaches masked neighbours.
// Reset: counters, window and handshakes clear, threshold returns to 128;
//   the line memory is not cleared and needs no clearing pass.

module binary_edge_detect_3x3 (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            pixel_valid,
    output logic                 pixel_stall,
    input  wire bedge_pkg::pix_t pixel_item,
    output logic                 result_valid,
    input  wire logic            result_stall,
    output bedge_pkg::res_t      result_item,
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic [7:0]      cfg_data
);

    logic [7:0]                  threshold_reg;
    logic [bedge_pkg::CNT_W-1:0] rx_cnt_reg, rx_cnt_next;
    logic [bedge_pkg::COL_W-1:0] rx_col_reg, rx_col_next;
    logic [bedge_pkg::COL_W-1:0] em_col_reg, em_col_next;
    logic [bedge_pkg::COL_W-1:0] em_row_reg, em_row_next;
    logic                        b_valid_reg, b_valid_next;
    bedge_pkg::stage_t           b_reg, b_next;
    logic [8:0]                  window_reg, window_next;
    logic                        result_valid_reg, result_valid_next;
    bedge_pkg::res_t             result_reg, result_next;

    logic                        accept;
    logic                        rx_full;
    logic                        a_push;
    logic                        a_emit;
    logic                        a_last;
    logic [bedge_pkg::COL_W-1:0] drain_col;
    logic                        out_free;
    logic                        b_go;
    logic [1:0]                  line_rdata;
    logic [1:0]                  line_wdata;
    logic                        line_we;
    logic                        line_re;
    logic [bedge_pkg::COL_W-1:0] line_raddr;
    logic [8:0]                  mask;
    logic                        is_edge;

    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result_item  = result_reg;

    assign out_free    = !result_valid_reg || !result_stall;
    assign b_go        = b_valid_reg && (!b_reg.emit || out_free);
    assign pixel_stall = b_valid_reg && !b_go;
    assign accept      = pixel_valid && !pixel_stall;

    assign rx_full   = (rx_cnt_reg == bedge_pkg::FRAME_PIXELS);
    assign drain_col = (em_col_reg == bedge_pkg::LAST_COL) ? '0 : em_col_reg + 1'b1;
    assign a_last    = (em_col_reg == bedge_pkg::LAST_COL) && (em_row_reg == bedge_pkg::LAST_COL);

    always_comb
    begin
        if (pixel_item.command == bedge_pkg::CMD_DRAIN)
        begin
            a_push = rx_full;
            a_emit = rx_full;
        end
        else
        begin
            a_push = !rx_full;
            a_emit = !rx_full && (rx_cnt_reg >= bedge_pkg::LEAD_PIXELS);
        end
    end

    // stage A: decide, advance counters, issue line read
    always_comb
    begin
        rx_cnt_next = rx_cnt_reg;
        rx_col_next = rx_col_reg;
        em_col_next = em_col_reg;
        em_row_next = em_row_reg;
        if (accept && a_push && pixel_item.command == bedge_pkg::CMD_PIXEL)
        begin
            rx_cnt_next = rx_cnt_reg + 1'b1;
            rx_col_next = (rx_col_reg == bedge_pkg::LAST_COL) ? '0 : rx_col_reg + 1'b1;
        end
        if (accept && a_emit)
        begin
            if (em_col_reg == bedge_pkg::LAST_COL)
            begin
                em_col_next = '0;
                em_row_next = em_row_reg + 1'b1;
            end
            else
            begin
                em_col_next = em_col_reg + 1'b1;
            end
            if (a_last)
            begin
                rx_cnt_next = '0;
                rx_col_next = '0;
                em_col_next = '0;
                em_row_next = '0;
            end
        end
    end

    assign line_re    = accept && a_push;
    assign line_raddr = (pixel_item.command == bedge_pkg::CMD_DRAIN) ? drain_col : rx_col_reg;

    always_comb
    begin
        b_next.emit          = a_emit;
        b_next.bit_in        = (pixel_item.command == bedge_pkg::CMD_PIXEL)
                               && (pixel_item.pixel_value > threshold_reg);
        b_next.col           = line_raddr;
        b_next.border.left   = (em_col_reg == '0);
        b_next.border.right  = (em_col_reg == bedge_pkg::LAST_COL);
        b_next.border.top    = (em_row_reg == '0);
        b_next.border.bottom = (em_row_reg == bedge_pkg::LAST_COL);
        b_next.last          = a_last;
        if (line_re)
        begin
            b_valid_next = 1'b1;
        end
        else if (b_go)
        begin
            b_valid_next = 1'b0;
        end
        else
        begin
            b_valid_next = b_valid_reg;
        end
    end

    bedge_ram #(
        .WIDTH (2),
        .DEPTH (bedge_pkg::IMAGE_SIDE)
    ) u_line_ram (
        .clk   (clk),
        .we    (line_we),
        .waddr (b_reg.col),
        .wdata (line_wdata),
        .re    (line_re),
        .raddr (line_raddr),
        .rdata (line_rdata)
    );

    // stage B: shift window, write lines back, form result
    assign line_we    = b_go;
    assign line_wdata = {b_reg.bit_in, line_rdata[1]};

    always_comb
    begin
        mask = bedge_pkg::NEIGHBOUR_MASK;
        if (b_reg.border.left)
        begin
            mask = mask & ~bedge_pkg::LEFT_COLUMN;
        end
        if (b_reg.border.right)
        begin
            mask = mask & ~bedge_pkg::RIGHT_COLUMN;
        end
        if (b_reg.border.top)
        begin
            mask = mask & ~bedge_pkg::TOP_ROW;
        end
        if (b_reg.border.bottom)
        begin
            mask = mask & ~bedge_pkg::BOTTOM_ROW;
        end
        window_next = {b_reg.bit_in, line_rdata[1], line_rdata[0], window_reg[8:3]};
        is_edge     = !window_next[4] && ((window_next & mask) != '0);
    end

    always_comb
    begin
        result_next.edge_pixel    = is_edge ? bedge_pkg::EDGE_BOUNDARY : bedge_pkg::EDGE_OTHER;
        result_next.last_of_frame = b_reg.last;
        if (b_go && b_reg.emit)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg    <= bedge_pkg::THRESHOLD_RESET;
            rx_cnt_reg       <= '0;
            rx_col_reg       <= '0;
            em_col_reg       <= '0;
            em_row_reg       <= '0;
            b_valid_reg      <= 1'b0;
            window_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                threshold_reg <= cfg_data;
            end
            rx_cnt_reg       <= rx_cnt_next;
            rx_col_reg       <= rx_col_next;
            em_col_reg       <= em_col_next;
            em_row_reg       <= em_row_next;
            b_valid_reg      <= b_valid_next;
            result_valid_reg <= result_valid_next;
            if (b_go)
            begin
                window_reg <= window_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (line_re)
        begin
            b_reg <= b_next;
        end
        if (b_go && b_reg.emit)
        begin
            result_reg <= result_next;
        end
    end

    a_no_line_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (line_we && line_re && !b_reg.last) |-> (b_reg.col != line_raddr))
        else $error("line memory read and write hit the same column");

    a_rx_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        rx_cnt_reg <= bedge_pkg::FRAME_PIXELS)
        else $error("pixel count beyond frame size");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(b_go && b_reg.emit))
        else $error("result raised without an emitting item");

    a_result_values: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (result_reg.edge_pixel == bedge_pkg::EDGE_BOUNDARY
                              || result_reg.edge_pixel == bedge_pkg::EDGE_OTHER))
        else $error("edge pixel outside its two values");

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_stall |-> (b_valid_reg && b_reg.emit && result_valid_reg))
        else $error("input stalled with nothing held");

endmodule

`default_nettype wire

// ===== tb/binary_edge_detect_3x3_tb.sv =====
module binary_edge_detect_3x3_tb;
    import bedge_pkg::*;

    localparam int unsigned SIDE  = IMAGE_SIDE;
    localparam int unsigned FRAME = IMAGE_SIDE * IMAGE_SIDE;

    localparam int QUIET_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 4;
    localparam int RUN_PIXELS    = 1550;
    localparam int TAIL_DRAINS   = 4;
    localparam int PHASE_PIXELS  = 256;
    localparam int REPORT_MAX    = 10;
    localparam int DIR_ROWS      = 24;

    typedef enum logic [1:0] {
        ROW_PIXEL,
        ROW_DRAIN,
        ROW_THRESH
    } row_op_e;

    typedef struct packed {
        row_op_e    op;
        logic [7:0] value;
        logic       silent;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic pixel_valid;
    logic pixel_stall;
    pix_t pixel_item;
    logic result_valid;
    logic result_stall;
    res_t result_item;
    logic cfg_valid;
    logic cfg_ready;
    logic [7:0] cfg_data;

    binary_edge_detect_3x3 u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel_item   (pixel_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    // binarised line stores, 3x3 window and frame progress of the predictor
    logic        upper_bits  [SIDE];
    logic        middle_bits [SIDE];
    logic [8:0]  window;
    int unsigned pixels_in;
    int unsigned edges_out;
    logic [7:0]  model_thresh;
    res_t        edges_due [$];

    int  fails;
    int  quiet_cycles;
    int  idle_pct;
    int  stall_pct;
    int  holds_asked;
    int  holds_done;
    bit  typed_silent;

    dir_row_t dir_rows [DIR_ROWS] = '{
        '{ROW_DRAIN,  8'h00, 1'b1},
        '{ROW_PIXEL,  8'h80, 1'b1},
        '{ROW_PIXEL,  8'h81, 1'b1},
        '{ROW_THRESH, 8'h00, 1'b0},
        '{ROW_PIXEL,  8'h00, 1'b1},
        '{ROW_PIXEL,  8'h01, 1'b1},
        '{ROW_PIXEL,  8'hFF, 1'b1},
        '{ROW_DRAIN,  8'hFF, 1'b1},
        '{ROW_THRESH, 8'hFF, 1'b0},
        '{ROW_PIXEL,  8'hFF, 1'b1},
        '{ROW_PIXEL,  8'h00, 1'b1},
        '{ROW_PIXEL,  8'hAA, 1'b1},
        '{ROW_THRESH, THRESHOLD_RESET, 1'b0},
        '{ROW_PIXEL,  8'h80, 1'b1},
        '{ROW_PIXEL,  8'h81, 1'b1},
        '{ROW_PIXEL,  8'h7F, 1'b1},
        '{ROW_PIXEL,  8'h55, 1'b1},
        '{ROW_THRESH, 8'h7F, 1'b0},
        '{ROW_PIXEL,  8'h80, 1'b1},
        '{ROW_PIXEL,  8'h7F, 1'b1},
        '{ROW_DRAIN,  8'h55, 1'b1},
        '{ROW_PIXEL,  8'hFE, 1'b1},
        '{ROW_PIXEL,  8'h01, 1'b1},
        '{ROW_DRAIN,  8'hAA, 1'b1}
    };

    function automatic void shift_window(int unsigned col, logic white);
        window = {white, middle_bits[col], upper_bits[col], window[8:3]};
        upper_bits[col]  = middle_bits[col];
        middle_bits[col] = white;
    endfunction

    function automatic res_t boundary_pixel();
        res_t        r;
        logic [8:0]  m;
        int unsigned row;
        int unsigned col;
        row = edges_out / SIDE;
        col = edges_out % SIDE;
        m = NEIGHBOUR_MASK;
        if (col == 0)
            m &= ~LEFT_COLUMN;
        if (col + 1 >= SIDE)
            m &= ~RIGHT_COLUMN;
        if (row == 0)
            m &= ~TOP_ROW;
        if (row + 1 >= SIDE)
            m &= ~BOTTOM_ROW;
        r.edge_pixel    = (!window[4] && (window & m) != '0) ? EDGE_BOUNDARY : EDGE_OTHER;
        r.last_of_frame = 1'b0;
        edges_out++;
        if (edges_out >= FRAME)
        begin
            r.last_of_frame = 1'b1;
            pixels_in = 0;
            edges_out = 0;
        end
        return r;
    endfunction

    function automatic bit predict_edge(pix_t it, output res_t r);
        int unsigned seen;
        seen = pixels_in;
        r = '0;
        if (it.command == CMD_PIXEL)
        begin
            if (seen >= FRAME)
                return 1'b0;
            shift_window(seen % SIDE, it.pixel_value > model_thresh);
            pixels_in = seen + 1;
            if (seen < SIDE + 1)
                return 1'b0;
            r = boundary_pixel();
            return 1'b1;
        end
        if (seen < FRAME || edges_out >= FRAME)
            return 1'b0;
        shift_window((edges_out + SIDE + 1) % SIDE, 1'b0);
        r = boundary_pixel();
        return 1'b1;
    endfunction

    function automatic void log_fail(string what);
        fails++;
        if (fails <= REPORT_MAX)
            $display("%s", what);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        window       = '0;
        pixels_in    = 0;
        edges_out    = 0;
        model_thresh = THRESHOLD_RESET;
        fails        = 0;
        quiet_cycles = 0;
        holds_done   = 0;
        for (int i = 0; i < SIDE; i++)
        begin
            upper_bits[i]  = 1'b0;
            middle_bits[i] = 1'b0;
        end
    end

    always @(posedge clk)
    begin : track_results
        res_t r;
        res_t want;
        bit   got;
        bit   busy;
        if (rst_n)
        begin
            busy = 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                model_thresh = cfg_data;
                busy = 1'b1;
            end
            if (pixel_valid && !pixel_stall)
            begin
                got = predict_edge(pixel_item, r);
                if (got && !typed_silent)
                    edges_due.push_back(r);
                busy = 1'b1;
            end
            if (result_valid && !result_stall)
            begin
                busy = 1'b1;
                if (edges_due.size() == 0)
                    log_fail($sformatf("unexpected result: edge %0d last %0b",
                                       result_item.edge_pixel, result_item.last_of_frame));
                else
                begin
                    want = edges_due.pop_front();
                    if (want.edge_pixel !== result_item.edge_pixel ||
                        want.last_of_frame !== result_item.last_of_frame)
                        log_fail($sformatf("expected edge %0d last %0b, got edge %0d last %0b",
                                           want.edge_pixel, want.last_of_frame,
                                           result_item.edge_pixel, result_item.last_of_frame));
                end
            end
            quiet_cycles = busy ? 0 : quiet_cycles + 1;
        end
    end

    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_asked != holds_done)
            begin
                // hold the output side while the sender keeps offering
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                holds_done++;
            end
            else
                result_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    task automatic send_item(logic cmd, logic [7:0] val, bit silent);
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            pixel_valid <= 1'b0;
        end
        @(negedge clk);
        pixel_valid  <= 1'b1;
        pixel_item   <= pix_t'{command: cmd, pixel_value: val};
        typed_silent = silent;
        do
            @(posedge clk);
        while (pixel_stall);
    endtask

    task automatic settle();
        @(negedge clk);
        pixel_valid <= 1'b0;
        while (edges_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(logic [7:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        int unsigned fed;
        int unsigned next_phase;
        int unsigned phase;
        logic [7:0]  v;
        logic [7:0]  thresh;
        logic        blob;
        rst_n        = 1'b0;
        pixel_valid  = 1'b0;
        pixel_item   = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        typed_silent = 1'b0;
        idle_pct     = 0;
        stall_pct    = 0;
        holds_asked  = 0;
        fed          = 0;
        phase        = 0;
        blob         = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].op == ROW_THRESH)
            begin
                settle();
                write_threshold(dir_rows[i].value);
            end
            else
            begin
                send_item(dir_rows[i].op == ROW_DRAIN ? CMD_DRAIN : CMD_PIXEL,
                          dir_rows[i].value, dir_rows[i].silent);
                if (dir_rows[i].op == ROW_PIXEL)
                    fed++;
            end
        end

        next_phase = 0;
        while (fed < RUN_PIXELS)
        begin
            if (fed >= next_phase)
            begin
                next_phase += PHASE_PIXELS;
                settle();
                case (phase % 6)
                    0:       thresh = 8'h00;
                    3:       thresh = 8'hFF;
                    default: thresh = 8'($urandom_range(255));
                endcase
                write_threshold(thresh);
                case (phase % 4)
                    0:       begin idle_pct = 0;  stall_pct = 0;  end
                    1:       begin idle_pct = 52; stall_pct = 0;  end
                    2:       begin idle_pct = 0;  stall_pct = 52; end
                    default: begin idle_pct = 18; stall_pct = 18; end
                endcase
                holds_asked++;
                phase++;
            end
            if ($urandom_range(31) == 0)
                send_item(CMD_DRAIN, 8'($urandom_range(255)), 1'b0);
            else
            begin
                case ($urandom_range(3))
                    0: v = 8'($urandom_range(255));
                    1: v = (model_thresh == 8'hFF || $urandom_range(1) == 0) ?
                           model_thresh : model_thresh + 8'd1;
                    default:
                    begin
                        if ($urandom_range(15) == 0)
                            blob = ~blob;
                        v = blob ? 8'($urandom_range(255, 200)) : 8'($urandom_range(50));
                    end
                endcase
                send_item(CMD_PIXEL, v, 1'b0);
                fed++;
            end
        end
        // drains before the frame is complete are dropped
        repeat (TAIL_DRAINS) send_item(CMD_DRAIN, 8'($urandom_range(255)), 1'b0);

        settle();
        repeat (8) @(posedge clk);
        if (fails == 0 && edges_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
